### sv/shbl_pkg.sv
// Shared constants, codes and types for the span header bitmap lookup.
package shbl_pkg;

   // Bits held in one bitmap word.
   localparam int SHBL_WORD_BITS = 64;
   localparam int SHBL_BIT_W     = 6;

   // Highest word count the 5-bit write index can reach.
   localparam int SHBL_WRITE_WORDS = 32;

   // Field widths.
   localparam int SHBL_OP_W     = 2;
   localparam int SHBL_WIDX_W   = 5;
   localparam int SHBL_OFFSET_W = 32;
   localparam int SHBL_SPAN_W   = 11;

   // Parameter defaults.
   localparam int SHBL_BITMAP_WORDS = 32;
   localparam int SHBL_PAGE_SHIFT   = 21;

   // Operation codes.
   localparam logic [SHBL_OP_W-1:0] SHBL_OP_WR_HDR = 2'd0;
   localparam logic [SHBL_OP_W-1:0] SHBL_OP_WR_OCC = 2'd1;
   localparam logic [SHBL_OP_W-1:0] SHBL_OP_LOOKUP = 2'd2;

   // Lookup sequencer states.
   typedef enum logic [1:0] {
      SHBL_IDLE,
      SHBL_CHECK,
      SHBL_SCAN
   } shbl_state_type;

   // Outcome of the highest-set-bit search over one word.
   typedef struct packed {
      logic                  found;
      logic [SHBL_BIT_W-1:0] index;
   } shbl_hit_type;

endpackage

### sv/shbl_top_bit.sv
// Highest-set-bit search over one bitmap word, optionally masked at a page bit.
module shbl_top_bit (
   input  logic [shbl_pkg::SHBL_WORD_BITS-1:0] word,
   input  logic                                use_limit,
   input  logic [shbl_pkg::SHBL_BIT_W-1:0]     limit_bit,
   output shbl_pkg::shbl_hit_type              hit
);
   import shbl_pkg::*;

   logic [SHBL_WORD_BITS-1:0] masked;
   logic [SHBL_WORD_BITS-1:0] limit_mask;

   // Keep bits at or below the limit; bit 63 wraps to an all-ones mask.
   assign limit_mask = (SHBL_WORD_BITS'(2) << limit_bit) - SHBL_WORD_BITS'(1);
   assign masked     = use_limit ? (word & limit_mask) : word;

   // Binary search by halves: six levels, each picks the upper half if it holds a bit.
   always_comb begin
      logic [SHBL_WORD_BITS-1:0] v;
      logic [SHBL_WORD_BITS-1:0] hi;
      logic [SHBL_BIT_W-1:0]     idx;
      v   = masked;
      idx = '0;
      for (int l = SHBL_BIT_W - 1; l >= 0; l--) begin
         hi = v >> (1 << l);
         if ((hi & ((SHBL_WORD_BITS'(1) << (1 << l)) - SHBL_WORD_BITS'(1))) != '0) begin
            idx[l] = 1'b1;
            v      = hi;
         end
      end
      hit.found = |masked;
      hit.index = idx;
   end

endmodule

### sv/span_header_bitmap_lookup.sv
// Span header lookup over header and occupancy page bitmaps, with backward word scan.
//
//   channel   ports                        handshake
//   --------  ---------------------------  -------------------------------------
//   request   req_operation .. byte_offset  taken at clock edge with start & !busy
//   result    rsp_span_page, rsp_not_*      one-cycle strobe rsp_valid, no stall
//
// A bitmap word write leaves busy low. A lookup holds busy through the check
// state and, when needed, the scan state, which reads the lower header words
// backward (0 to min(BITMAP_WORDS,32)-1 of them); the result strobe follows in
// the next cycle. The scan rate is set by the bitmap memory's single registered
// read port, one word per cycle. Reset clears the per-word valid flags at once,
// so no clearing pass is needed. The receiver cannot stall.
module span_header_bitmap_lookup #(
   parameter int BITMAP_WORDS = shbl_pkg::SHBL_BITMAP_WORDS,
   parameter int PAGE_SHIFT   = shbl_pkg::SHBL_PAGE_SHIFT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [shbl_pkg::SHBL_OP_W-1:0]      req_operation,
   input  logic [shbl_pkg::SHBL_WIDX_W-1:0]    req_word_index,
   input  logic [shbl_pkg::SHBL_WORD_BITS-1:0] req_word_data,
   input  logic [shbl_pkg::SHBL_OFFSET_W-1:0]  req_byte_offset,
   output logic                                rsp_valid,
   output logic [shbl_pkg::SHBL_SPAN_W-1:0]    rsp_span_page,
   output logic                                rsp_not_occupied,
   output logic                                rsp_not_found
);
   import shbl_pkg::*;

   // Words beyond the write index reach always read as zero, so only these are stored.
   localparam int MEM_WORDS = (BITMAP_WORDS < SHBL_WRITE_WORDS) ? BITMAP_WORDS
                                                                : SHBL_WRITE_WORDS;
   localparam int IDX_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   // Bitmap storage with valid flags standing in for the all-zero reset.
   logic [SHBL_WORD_BITS-1:0] hdr_mem [MEM_WORDS];
   logic [SHBL_WORD_BITS-1:0] occ_mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]      hdr_vld_ff, occ_vld_ff;
   logic [SHBL_WORD_BITS-1:0] hdr_rd_ff, occ_rd_ff;
   logic                      hdr_rdv_ff, occ_rdv_ff;

   shbl_state_type        state_ff, state_in;
   logic [IDX_W-1:0]      word_ff, word_in;
   logic [SHBL_BIT_W-1:0] bit_ff, bit_in;
   logic                  in_range_ff, in_range_in;
   logic                  page_zero_ff, page_zero_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SHBL_SPAN_W-1:0] rsp_page_ff, rsp_page_in;
   logic                   rsp_unocc_ff, rsp_unocc_in;
   logic                   rsp_nf_ff, rsp_nf_in;

   logic                      accept;
   logic                      hdr_we, occ_we;
   logic [IDX_W-1:0]          rd_addr;
   logic [SHBL_OFFSET_W-1:0]  req_page;
   logic [SHBL_OFFSET_W-1:0]  req_word;
   logic [SHBL_WORD_BITS-1:0] hdr_word, occ_word;
   logic                      occupied;
   logic [SHBL_SPAN_W-1:0]    hit_page;
   shbl_hit_type              hit;

   assign accept   = start && !busy;
   assign busy     = (state_ff != SHBL_IDLE);
   assign req_page = req_byte_offset >> PAGE_SHIFT;
   assign req_word = req_page >> SHBL_BIT_W;

   // Bitmap writes happen only while idle; reads run every cycle.
   assign hdr_we = accept && (req_operation == SHBL_OP_WR_HDR)
                   && (32'(req_word_index) < 32'(MEM_WORDS));
   assign occ_we = accept && (req_operation == SHBL_OP_WR_OCC)
                   && (32'(req_word_index) < 32'(MEM_WORDS));
   assign rd_addr = (state_ff == SHBL_IDLE) ? req_word[IDX_W-1:0] : (word_ff - IDX_W'(1));

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[req_word_index[IDX_W-1:0]] <= req_word_data;
      end
      if (occ_we) begin
         occ_mem[req_word_index[IDX_W-1:0]] <= req_word_data;
      end
      hdr_rd_ff  <= hdr_mem[rd_addr];
      occ_rd_ff  <= occ_mem[rd_addr];
      hdr_rdv_ff <= hdr_vld_ff[rd_addr];
      occ_rdv_ff <= occ_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_vld_ff <= '0;
         occ_vld_ff <= '0;
      end else begin
         if (hdr_we) begin
            hdr_vld_ff[req_word_index[IDX_W-1:0]] <= 1'b1;
         end
         if (occ_we) begin
            occ_vld_ff[req_word_index[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Unwritten words read as zero.
   assign hdr_word = hdr_rdv_ff ? hdr_rd_ff : '0;
   assign occ_word = occ_rdv_ff ? occ_rd_ff : '0;
   assign occupied = in_range_ff && occ_word[bit_ff];

   // Shared search unit: masked in the page's own word, whole word while scanning.
   shbl_top_bit u_top_bit (
      .word      (hdr_word),
      .use_limit (state_ff == SHBL_CHECK),
      .limit_bit (bit_ff),
      .hit       (hit)
   );

   assign hit_page = (SHBL_SPAN_W'(word_ff) << SHBL_BIT_W) | SHBL_SPAN_W'(hit.index);

   // Sequencer: next state, scan word and result.
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      in_range_in  = in_range_ff;
      page_zero_in = page_zero_ff;
      rsp_valid_in = 1'b0;
      rsp_page_in  = rsp_page_ff;
      rsp_unocc_in = rsp_unocc_ff;
      rsp_nf_in    = rsp_nf_ff;
      unique case (state_ff)
         SHBL_IDLE: begin
            if (accept && (req_operation == SHBL_OP_LOOKUP)) begin
               word_in      = req_word[IDX_W-1:0];
               bit_in       = req_page[SHBL_BIT_W-1:0];
               in_range_in  = (req_word < 32'(MEM_WORDS));
               page_zero_in = (req_page == '0);
               state_in     = SHBL_CHECK;
            end
         end
         SHBL_CHECK: begin
            rsp_page_in  = '0;
            rsp_unocc_in = 1'b0;
            rsp_nf_in    = 1'b0;
            priority if (!occupied) begin
               rsp_valid_in = 1'b1;
               rsp_unocc_in = 1'b1;
               state_in     = SHBL_IDLE;
            end else if (page_zero_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = SHBL_IDLE;
            end else if (hit.found) begin
               rsp_valid_in = 1'b1;
               rsp_page_in  = hit_page;
               state_in     = SHBL_IDLE;
            end else if (word_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_nf_in    = 1'b1;
               state_in     = SHBL_IDLE;
            end else begin
               word_in  = word_ff - IDX_W'(1);
               state_in = SHBL_SCAN;
            end
         end
         SHBL_SCAN: begin
            priority if (hit.found) begin
               rsp_valid_in = 1'b1;
               rsp_page_in  = hit_page;
               state_in     = SHBL_IDLE;
            end else if (word_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_nf_in    = 1'b1;
               state_in     = SHBL_IDLE;
            end else begin
               word_in = word_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = SHBL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SHBL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      in_range_ff  <= in_range_in;
      page_zero_ff <= page_zero_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_unocc_ff <= rsp_unocc_in;
      rsp_nf_ff    <= rsp_nf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_page    = rsp_page_ff;
   assign rsp_not_occupied = rsp_unocc_ff;
   assign rsp_not_found    = rsp_nf_ff;

   // A result only follows a lookup step.
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != SHBL_IDLE))
      else $error("result strobe without a lookup in progress");

   // The two error flags never stand together.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_not_occupied && rsp_not_found))
      else $error("not_occupied and not_found both set");

   // Error results carry a zero page.
   a_error_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_not_occupied || rsp_not_found)) |-> (rsp_span_page == '0))
      else $error("error result with nonzero span page");

   // The scan steps down one word per cycle.
   a_scan_descends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SHBL_SCAN) && $past(state_ff == SHBL_SCAN))
         |-> (word_ff == $past(word_ff) - IDX_W'(1)))
      else $error("scan word did not step down by one");

endmodule

### dv/span_header_bitmap_lookup_tb.sv
// Self-checking testbench for the span header bitmap lookup block.
module span_header_bitmap_lookup_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shbl_pkg::*;

   // Code 3 is undecoded by the block and must not touch either bitmap
   localparam logic [SHBL_OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1150;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PAGE_W         = SHBL_OFFSET_W - SHBL_PAGE_SHIFT;
   localparam int PAGE_COUNT     = 1 << PAGE_W;

   typedef struct {
      logic [SHBL_OP_W-1:0]      op;
      logic [SHBL_WIDX_W-1:0]    widx;
      logic [SHBL_WORD_BITS-1:0] data;
      logic [SHBL_OFFSET_W-1:0]  offset;
      int                        idle_pct;
      bit                        drain;
   } lookup_req_type;

   typedef struct packed {
      logic [SHBL_SPAN_W-1:0] span_page;
      logic                   not_occupied;
      logic                   not_found;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [SHBL_OP_W-1:0]      req_operation   = '0;
   logic [SHBL_WIDX_W-1:0]    req_word_index  = '0;
   logic [SHBL_WORD_BITS-1:0] req_word_data   = '0;
   logic [SHBL_OFFSET_W-1:0]  req_byte_offset = '0;
   logic                      rsp_valid;
   logic [SHBL_SPAN_W-1:0]    rsp_span_page;
   logic                      rsp_not_occupied;
   logic                      rsp_not_found;

   // Items waiting to be sent, the item on the ports, and lookups in flight
   lookup_req_type  pending_reqs[$];
   lookup_req_type  sent_req;
   span_result_type pending_spans[$];

   // Testbench copy of both bitmaps, updated in acceptance order
   logic [SHBL_WORD_BITS-1:0] hdr_shadow[SHBL_BITMAP_WORDS];
   logic [SHBL_WORD_BITS-1:0] occ_shadow[SHBL_BITMAP_WORDS];

   int accepted_items = 0;
   int total_items    = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   // Generation controls read by add_req
   int gen_idle_pct = 0;
   bit gen_drain    = 1'b0;
   int real_items   = 0;

   span_header_bitmap_lookup u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_word_index   (req_word_index),
      .req_word_data    (req_word_data),
      .req_byte_offset  (req_byte_offset),
      .rsp_valid        (rsp_valid),
      .rsp_span_page    (rsp_span_page),
      .rsp_not_occupied (rsp_not_occupied),
      .rsp_not_found    (rsp_not_found)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Highest set bit of a nonzero word
   function automatic int top_bit(logic [SHBL_WORD_BITS-1:0] w);
      int pos;
      pos = 0;
      for (int k = 0; k < SHBL_WORD_BITS; k++) begin
         if (w[k]) pos = k;
      end
      return pos;
   endfunction

   // Expected outcome of a lookup against the current shadow bitmaps
   function automatic span_result_type predict_lookup(logic [SHBL_OFFSET_W-1:0] offset);
      span_result_type           r;
      int                        page;
      int                        wrd;
      int                        b;
      logic [SHBL_WORD_BITS-1:0] cand;
      r    = '0;
      page = offset >> SHBL_PAGE_SHIFT;
      wrd  = page >> SHBL_BIT_W;
      b    = page % SHBL_WORD_BITS;
      if (wrd >= SHBL_BITMAP_WORDS) r.not_occupied = 1'b1;
      else r.not_occupied = !occ_shadow[wrd][b];
      if (!r.not_occupied && page != 0) begin
         r.not_found = 1'b1;
         for (int w = wrd; w >= 0; w--) begin
            // own word is masked to bits at or below the page
            cand = hdr_shadow[w];
            if (w == wrd) cand = cand & ((64'd2 << b) - 64'd1);
            if (cand != 0) begin
               r.span_page = SHBL_SPAN_W'(w * SHBL_WORD_BITS + top_bit(cand));
               r.not_found = 1'b0;
               break;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [SHBL_WORD_BITS-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offset somewhere inside the given page
   function automatic logic [SHBL_OFFSET_W-1:0] page_offset(int page);
      logic [SHBL_OFFSET_W-1:0] o;
      o = $urandom;
      o[SHBL_OFFSET_W-1:SHBL_PAGE_SHIFT] = PAGE_W'(page);
      return o;
   endfunction

   task automatic add_req(logic [SHBL_OP_W-1:0] op, int widx,
                          logic [SHBL_WORD_BITS-1:0] data,
                          logic [SHBL_OFFSET_W-1:0] offset);
      lookup_req_type it;
      it.op       = op;
      it.widx     = SHBL_WIDX_W'(widx);
      it.data     = data;
      it.offset   = offset;
      it.idle_pct = gen_idle_pct;
      it.drain    = gen_drain;
      gen_drain   = 1'b0;
      pending_reqs.push_back(it);
      real_items++;
   endtask

   // Stimulus: directed corners first, then random traffic in three idle phases
   initial begin
      int sel;
      int page;
      int phase;
      int prev_phase;
      logic [SHBL_WORD_BITS-1:0] d;

      for (int i = 0; i < SHBL_BITMAP_WORDS; i++) begin
         hdr_shadow[i] = '0;
         occ_shadow[i] = '0;
      end

      gen_idle_pct = 24;
      // both bitmaps empty after reset: page 0 and top page unoccupied
      add_req(SHBL_OP_LOOKUP, 0, rand64(), 32'h0000_0000);
      add_req(SHBL_OP_LOOKUP, 31, rand64(), 32'hFFFF_FFFF);
      add_req(SHBL_OP_WR_OCC, 0, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      // occupied page zero returns zero even with no headers
      add_req(SHBL_OP_LOOKUP, 0, '0, 32'h0000_0000);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(1));
      add_req(SHBL_OP_WR_HDR, 0, 64'h1, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, {11'd63, 21'h1F_FFFF});
      // top page scans every word down to word 0
      add_req(SHBL_OP_WR_OCC, 31, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, 32'hFFFF_FFFF);
      add_req(SHBL_OP_WR_HDR, 31, 64'h8000_0000_0000_0000, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, 32'hFFFF_FFFF);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(1984));
      add_req(SHBL_OP_WR_HDR, 17, 64'h0000_0400_0000_0000, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(1989));
      add_req(SHBL_OP_WR_OCC, 17, 64'hAAAA_AAAA_AAAA_AAAA, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(17 * 64 + 42));
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(17 * 64 + 43));
      // undecoded op must leave header word 17 alone
      add_req(OP_UNUSED, 17, '0, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(1989));
      // occupancy is checked before the page zero shortcut
      add_req(SHBL_OP_WR_HDR, 0, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      add_req(SHBL_OP_WR_OCC, 0, 64'hFFFF_FFFF_FFFF_FFFE, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, 32'h0000_1234);
      add_req(SHBL_OP_LOOKUP, 0, '0, page_offset(63));
      add_req(SHBL_OP_WR_HDR, 0, '0, $urandom);
      add_req(SHBL_OP_WR_HDR, 17, '0, $urandom);
      add_req(SHBL_OP_WR_HDR, 31, '0, $urandom);
      add_req(SHBL_OP_LOOKUP, 0, '0, 32'hFFFF_FFFF);

      gen_drain  = 1'b1;
      prev_phase = 0;
      while (real_items < ITEM_TARGET) begin
         phase = (real_items < ITEM_TARGET / 3) ? 0 :
                 (real_items < 2 * ITEM_TARGET / 3) ? 1 : 2;
         gen_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 46 : 0;
         if (phase != prev_phase || $urandom_range(0, 99) == 0) gen_drain = 1'b1;
         prev_phase = phase;
         sel = $urandom_range(0, 99);
         if (sel < 52) begin
            // lookup, biased toward the top word and word zero
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               add_req(SHBL_OP_LOOKUP, $urandom_range(0, 31), rand64(), $urandom);
            end else begin
               if (sel < 22) page = $urandom_range(PAGE_COUNT - 64, PAGE_COUNT - 1);
               else if (sel < 32) page = $urandom_range(0, 63);
               else page = $urandom_range(0, PAGE_COUNT - 1);
               add_req(SHBL_OP_LOOKUP, $urandom_range(0, 31), rand64(), page_offset(page));
            end
         end else if (sel < 72) begin
            // header words mostly sparse so scans run deep
            sel = $urandom_range(0, 99);
            if (sel < 45) d = '0;
            else if (sel < 70) d = 64'd1 << $urandom_range(0, 63);
            else if (sel < 90) d = rand64();
            else d = '1;
            add_req(SHBL_OP_WR_HDR, $urandom_range(0, 31), d, $urandom);
         end else if (sel < 91) begin
            // occupancy words mostly dense so lookups get past the check
            sel = $urandom_range(0, 99);
            if (sel < 40) d = '1;
            else if (sel < 75) d = rand64();
            else if (sel < 85) d = '0;
            else d = rand64() & rand64() & rand64();
            add_req(SHBL_OP_WR_OCC, $urandom_range(0, 31), d, $urandom);
         end else if (sel < 96) begin
            add_req(OP_UNUSED, $urandom_range(0, 31), rand64(), $urandom);
         end else begin
            // wipe headers, usually plant one low header, then look up from the top word
            for (int w = SHBL_BITMAP_WORDS - 1; w >= 0; w--)
               add_req(SHBL_OP_WR_HDR, w, '0, $urandom);
            if ($urandom_range(0, 3) != 0)
               add_req(SHBL_OP_WR_HDR, $urandom_range(0, 15),
                       64'd1 << $urandom_range(0, 63), $urandom);
            add_req(SHBL_OP_WR_OCC, 31, '1, $urandom);
            for (int k = 0; k < 4; k++)
               add_req(SHBL_OP_LOOKUP, 0, '0,
                       page_offset($urandom_range(PAGE_COUNT - 64, PAGE_COUNT - 1)));
         end
      end
      total_items = pending_reqs.size();

      // wait for every item and every lookup result, then let the block settle
      do @(posedge clock);
      while (accepted_items < total_items || pending_spans.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Request driver: predicts on acceptance, then presents the next item
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted_items++;
            unique case (sent_req.op)
               SHBL_OP_WR_HDR: begin
                  if (sent_req.widx < SHBL_BITMAP_WORDS) hdr_shadow[sent_req.widx] = sent_req.data;
               end
               SHBL_OP_WR_OCC: begin
                  if (sent_req.widx < SHBL_BITMAP_WORDS) occ_shadow[sent_req.widx] = sent_req.data;
               end
               SHBL_OP_LOOKUP: begin
                  pending_spans.push_back(predict_lookup(sent_req.offset));
               end
               default: begin
               end
            endcase
         end
         if (!start || !busy) begin
            if (pending_reqs.size() != 0
                && $urandom_range(0, 99) >= pending_reqs[0].idle_pct
                && !(pending_reqs[0].drain && pending_spans.size() != 0)) begin
               sent_req = pending_reqs.pop_front();
               start           <= 1'b1;
               req_operation   <= sent_req.op;
               req_word_index  <= sent_req.widx;
               req_word_data   <= sent_req.data;
               req_byte_offset <= sent_req.offset;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor and watchdog
   always @(posedge clock) begin : rsp_monitor
      span_result_type want;
      if (!reset) begin
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            if ((start && !busy) || rsp_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (rsp_valid) begin
               if (pending_spans.size() == 0) begin
                  $error("unexpected result: span_page=%0d not_occupied=%0b not_found=%0b",
                         rsp_span_page, rsp_not_occupied, rsp_not_found);
                  mismatch_count++;
               end else begin
                  want = pending_spans.pop_front();
                  if (rsp_span_page !== want.span_page) begin
                     $error("span_page: expected %0d, actual %0d", want.span_page, rsp_span_page);
                     mismatch_count++;
                  end
                  if (rsp_not_occupied !== want.not_occupied) begin
                     $error("not_occupied: expected %0b, actual %0b",
                            want.not_occupied, rsp_not_occupied);
                     mismatch_count++;
                  end
                  if (rsp_not_found !== want.not_found) begin
                     $error("not_found: expected %0b, actual %0b", want.not_found, rsp_not_found);
                     mismatch_count++;
                  end
               end
            end
         end
      end
   end

endmodule

### span_header_bitmap_lookup.f
sv/shbl_pkg.sv
sv/shbl_top_bit.sv
sv/span_header_bitmap_lookup.sv
dv/span_header_bitmap_lookup_tb.sv
